// ===== hw/rtl/bb3_pkg.sv =====
// Shared types, constants and the reciprocal table of the 3x3 box blur.
// No dependencies; used by the controller, the datapath and the top level.
package bb3_pkg;

	localparam int unsigned FW_BITS   = 11;  // frame_width register
	localparam int unsigned FH_BITS   = 16;  // frame_height register
	localparam int unsigned CFG_BITS  = 16;  // widest register
	localparam int unsigned ROW_BITS  = 17;
	localparam int unsigned CH_BITS   = 8;
	localparam int unsigned PIX_BITS  = 24;
	localparam int unsigned SUM_BITS  = 12;  // 9 * 255
	localparam int unsigned NUM_BITS  = 13;  // 2 * sum + n
	localparam int unsigned RCP_BITS  = 20;
	localparam int unsigned RCP_SHIFT = 20;
	localparam int unsigned PROD_BITS = NUM_BITS + RCP_BITS;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic acc;   // capture request, read line stores
		logic upd;   // shift window, write line stores, advance position
		logic sum;   // add masked window
		logic div;   // multiply by reciprocal
		logic load;  // move result into output register
	} bb3_cmd_t;

	typedef struct packed {
		logic hit;       // the request gives a result
		logic out_free;  // output register can take a result
	} bb3_sts_t;

	// ceil(2^20 / (2n)); exact for numerators below 2^13
	function automatic logic [RCP_BITS-1:0] recip(input logic [3:0] n);
		logic [RCP_BITS-1:0] r;
		unique case (n)
			4'd1:    r = 20'd524288;
			4'd2:    r = 20'd262144;
			4'd3:    r = 20'd174763;
			4'd4:    r = 20'd131072;
			4'd5:    r = 20'd104858;
			4'd6:    r = 20'd87382;
			4'd7:    r = 20'd74899;
			4'd8:    r = 20'd65536;
			4'd9:    r = 20'd58255;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/box_blur_3x3_stream.sv =====
// Top level of the streaming 3x3 box blur.
// Joins bb3_ctrl and bb3_dp; uses bb3_pkg.
//
// Usage:
//  - Slave channel carries one pixel request per handshake: tdata holds red,
//    green, blue; tuser is the opcode (0 pixel, 1 drain).
//  - Master channel returns the blurred pixel; tlast flags the frame's final
//    result.
//  - Write frame_width (index 0) and frame_height (index 1) while idle; each
//    write restarts the frame.
//  - Results lag the input by frame_width+1 requests, so send frame_width+1
//    drain requests after the last pixel.
//  - Requests are taken one at a time: the sequencer steps read, update, sum
//    and, for a result, divide and load one after another before it accepts
//    the next request.
//  - A result moves through the capture, window, sum and product registers
//    into the output register; the load waits while that register is full.
//  - A stalled receiver holds the result in the output register; the next
//    request is still accepted and only waits at the load step.
//  - Reset clears position, window and output valid; width returns to 1024,
//    height to 1. Line store contents stay undefined and never reach a result.
module box_blur_3x3_stream
	import bb3_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [PIX_BITS-1:0] s_tdata,   // in_red, in_green, in_blue from bit 0
	input  logic                s_tuser,   // opcode
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [PIX_BITS-1:0] m_tdata,   // out_red, out_green, out_blue from bit 0
	output logic                m_tlast    // frame_end
);

	bb3_cmd_t cmd;
	bb3_sts_t sts;

	bb3_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// repack so red lands in the top byte internally
	bb3_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_op     (s_tuser),
		.in_pix    ({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// one request in flight: no back-to-back accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while previous still in work");

	// a pending result is never overwritten by the next request
	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("pending result lost or changed");

endmodule

// ===== hw/rtl/bb3_ctrl.sv =====
// Sequencer of the box blur: one request at a time through read, update,
// sum and, for a result, divide and output load. Depends on bb3_pkg.
module bb3_ctrl
	import bb3_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  bb3_sts_t sts,
	output bb3_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_UPD  = 5'b00010,
		ST_SUM  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_PUSH = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.acc  = s_tvalid;
				if (s_tvalid) state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = sts.hit ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				// hold until the output register frees up
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

// ===== hw/rtl/bb3_dp.sv =====
// Datapath of the box blur: configuration, line stores, window, position,
// edge mask, sums, reciprocal division and output register. Uses bb3_pkg.
module bb3_dp
	import bb3_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	input  logic                in_op,
	input  logic [PIX_BITS-1:0] in_pix,   // {red, green, blue}
	input  bb3_cmd_t            cmd,
	output bb3_sts_t            sts,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [PIX_BITS-1:0] m_tdata,  // red, green, blue from bit 0
	output logic                m_tlast
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

	logic [FW_BITS-1:0]  fw_q;
	logic [FH_BITS-1:0]  fh_q;
	logic [CW-1:0]       col_q;
	logic [ROW_BITS-1:0] row_q;
	logic [WW-1:0]       w_eff;
	logic [FH_BITS-1:0]  h_eff;
	logic [CW-1:0]       c_eff;

	logic [PIX_BITS-1:0] upper_mem [MAX_WIDTH];
	logic [PIX_BITS-1:0] middle_mem [MAX_WIDTH];

	logic [CW-1:0]       c_s1;
	logic [ROW_BITS-1:0] r_s1;
	logic [PIX_BITS-1:0] px_s1, up_s1, md_s1;

	logic [PIX_BITS-1:0] win_q [9];
	logic                hit_q, last_q;
	logic [8:0]          mask_q;

	logic [SUM_BITS-1:0]  sum_s2 [3];
	logic [3:0]           n_s2;
	logic [PROD_BITS-1:0] prod_s3 [3];
	logic                 last_s2, last_s3;

	logic                 out_valid_q, out_last_q;
	logic [PIX_BITS-1:0]  out_data_q;

	always_comb begin
		if (fw_q == '0)                    w_eff = WW'(1);
		else if (32'(fw_q) > MAX_WIDTH)    w_eff = WW'(MAX_WIDTH);
		else                               w_eff = WW'(fw_q);
		h_eff = (fh_q == '0) ? FH_BITS'(1) : fh_q;
		c_eff = (WW'(col_q) >= w_eff) ? '0 : col_q;
	end

	// position of the window centre and its in-frame neighbours
	logic [ROW_BITS-1:0] qr;
	logic [WW-1:0]       qc;
	logic                hit, last;
	logic [2:0]          row_ok, col_ok;
	logic [8:0]          mask;
	logic [WW:0]         c_next;

	always_comb begin
		qr  = (c_s1 == '0) ? r_s1 - ROW_BITS'(2) : r_s1 - ROW_BITS'(1);
		qc  = (c_s1 == '0) ? w_eff - WW'(1) : WW'(c_s1) - WW'(1);
		hit = !((r_s1 < ROW_BITS'(1)) || (c_s1 == '0 && r_s1 < ROW_BITS'(2)))
			&& (qr < ROW_BITS'(h_eff));
		row_ok[0] = (qr != '0);
		row_ok[1] = 1'b1;
		row_ok[2] = ((qr + ROW_BITS'(1)) < ROW_BITS'(h_eff));
		col_ok[0] = (qc != '0);
		col_ok[1] = 1'b1;
		col_ok[2] = (({1'b0, qc} + (WW+1)'(1)) < {1'b0, w_eff});
		for (int k = 0; k < 9; k++) mask[k] = row_ok[k / 3] & col_ok[k % 3];
		last   = (qr == ROW_BITS'(h_eff) - ROW_BITS'(1)) && (qc == w_eff - WW'(1));
		c_next = (WW+1)'(c_s1) + (WW+1)'(1);
	end

	// configuration and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= FW_BITS'(1024);
			fh_q  <= FH_BITS'(1);
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_WIDTH) fw_q <= cfg_data[FW_BITS-1:0];
			else                        fh_q <= cfg_data;
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.upd) begin
			if (hit && last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (c_next >= {1'b0, w_eff}) begin
				col_q <= '0;
				row_q <= r_s1 + ROW_BITS'(1);
			end else begin
				col_q <= c_next[CW-1:0];
			end
		end
	end

	// capture request and read the two line stores
	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			c_s1  <= c_eff;
			r_s1  <= row_q;
			px_s1 <= (in_op == OP_PIXEL) ? in_pix : '0;
			up_s1 <= upper_mem[c_eff];
			md_s1 <= middle_mem[c_eff];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			upper_mem[c_s1]  <= md_s1;
			middle_mem[c_s1] <= px_s1;
		end
	end

	// window shift and edge mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) win_q[k] <= '0;
			hit_q  <= 1'b0;
			last_q <= 1'b0;
			mask_q <= '0;
		end else if (cmd.upd) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]   <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= up_s1;
			win_q[5] <= md_s1;
			win_q[8] <= px_s1;
			hit_q    <= hit;
			last_q   <= last;
			mask_q   <= mask;
		end
	end

	// channel sums over the in-frame neighbours
	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			for (int ch = 0; ch < 3; ch++) begin
				logic [SUM_BITS-1:0] acc;
				acc = '0;
				for (int k = 0; k < 9; k++)
					if (mask_q[k])
						acc = acc + SUM_BITS'(win_q[k][ch*CH_BITS +: CH_BITS]);
				sum_s2[ch] <= acc;
			end
			n_s2    <= 4'($countones(mask_q));
			last_s2 <= last_q;
		end
	end

	// round-half-up mean: (2s + n) * ceil(2^20 / 2n) >> 20
	always_ff @(posedge clk) begin
		if (cmd.div) begin
			for (int ch = 0; ch < 3; ch++)
				prod_s3[ch] <= PROD_BITS'({sum_s2[ch], 1'b0} + NUM_BITS'(n_s2))
					* PROD_BITS'(recip(n_s2));
			last_s3 <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load) out_valid_q <= 1'b1;
		else if (m_tready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			// red sits at bit 0 on the output bus
			out_data_q <= {prod_s3[0][RCP_SHIFT +: CH_BITS],
				prod_s3[1][RCP_SHIFT +: CH_BITS], prod_s3[2][RCP_SHIFT +: CH_BITS]};
			out_last_q <= last_s3;
		end
	end

	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_data_q;
	assign m_tlast      = out_last_q;
	assign sts.hit      = hit_q;
	assign sts.out_free = !out_valid_q || m_tready;

endmodule
